// ===== rtl/gds_pkg.sv =====
package gds_pkg;

  // Grid and stack geometry.
  localparam int ROWS        = 32;
  localparam int COLS        = 32;
  localparam int STACK_DEPTH = 4096;

  localparam int ROW_W       = 5;
  localparam int COL_W       = 5;
  localparam int GRID_DEPTH  = ROWS * COLS;
  localparam int GRID_AW     = $clog2(GRID_DEPTH);
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int CNT_W       = STACK_AW + 1;
  localparam int STK_W       = ROW_W + COL_W;
  localparam int CELL_W      = 2;
  localparam int NBR_N       = 4;
  localparam int NBR_W       = 2;

  // Operation codes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SEED  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  // Cell states.
  localparam logic [CELL_W-1:0] CELL_OPEN    = 2'd0;
  localparam logic [CELL_W-1:0] CELL_WALL    = 2'd1;
  localparam logic [CELL_W-1:0] CELL_SOURCE  = 2'd2;
  localparam logic [CELL_W-1:0] CELL_VISITED = 2'd3;

  // Neighbour order: down, up, right, left.
  localparam logic [NBR_W-1:0] NBR_LAST = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POP,
    ST_CELL,
    ST_NBR
  } state_t;

  function automatic logic [GRID_AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
    int a;
    a = int'(r) * COLS + int'(c);
    return a[GRID_AW-1:0];
  endfunction

endpackage

// ===== rtl/grid_dfs_single_step.sv =====
// Single-stepped depth-first search over a four-neighbour grid with an explicit stack.
// A command word is taken at a rising edge where start is high and busy is low. Its
// operation is a cell write, a seed push onto the stack, or one search step.
// Every command yields exactly one result word, shown on the out_ ports for one cycle
// with out_valid high. The receiver cannot stall, so results are never held.
// Latency: a cell write or seed push gives its result in the cycle after acceptance,
// and start may be taken again in that same cycle. A search step on an empty stack
// also gives its result in the cycle after acceptance. Any other step is paced by
// the single grid memory read port: one read for the popped cell, which ends the step
// when that cell is already visited, then one for each of the four neighbours in turn
// when it is expanded. busy stays high until the result word appears.
// After reset the block runs a clearing pass over the grid memory, one cell a cycle,
// and holds busy high until all 1024 cells are open. The stack memory is not
// cleared, as only entries below the stack count are ever used.
module grid_dfs_single_step (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_operation,
  input  logic [gds_pkg::ROW_W-1:0]  in_row,
  input  logic [gds_pkg::COL_W-1:0]  in_col,
  input  logic [gds_pkg::CELL_W-1:0] in_cell_value,
  output logic                       out_valid,
  output logic                       out_changed,
  output logic [gds_pkg::ROW_W-1:0]  out_expanded_row,
  output logic [gds_pkg::COL_W-1:0]  out_expanded_col,
  output logic                       out_stack_empty,
  output logic                       out_overflow
);

  gds_pkg::state_t state_r, state_nxt;

  logic [gds_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [gds_pkg::GRID_AW-1:0] clr_r, clr_nxt;
  logic [gds_pkg::ROW_W-1:0]   pr_r, pr_nxt;
  logic [gds_pkg::COL_W-1:0]   pc_r, pc_nxt;
  logic [gds_pkg::NBR_W-1:0]   nb_r, nb_nxt;
  logic                        ovf_r, ovf_nxt;

  logic                        valid_r, valid_nxt;
  logic                        changed_r, changed_nxt;
  logic [gds_pkg::ROW_W-1:0]   erow_r, erow_nxt;
  logic [gds_pkg::COL_W-1:0]   ecol_r, ecol_nxt;
  logic                        empty_r, empty_nxt;
  logic                        oflag_r, oflag_nxt;

  // Grid memory port.
  logic                         g_we;
  logic [gds_pkg::GRID_AW-1:0]  g_waddr, g_raddr;
  logic [gds_pkg::CELL_W-1:0]   g_wdata, g_rdata;

  // Stack memory port.
  logic                         s_we;
  logic [gds_pkg::STACK_AW-1:0] s_waddr, s_raddr;
  logic [gds_pkg::STK_W-1:0]    s_wdata, s_rdata;

  // Neighbours of the popped cell, in the order down, up, right, left.
  logic [gds_pkg::ROW_W-1:0] nbr_row [gds_pkg::NBR_N];
  logic [gds_pkg::COL_W-1:0] nbr_col [gds_pkg::NBR_N];
  logic                      nbr_ok  [gds_pkg::NBR_N];

  logic accept;
  logic in_grid;
  logic stack_full;
  logic [gds_pkg::NBR_W-1:0] nb_inc;

  assign accept     = start && (state_r == gds_pkg::ST_IDLE);
  assign in_grid    = (int'(in_row) < gds_pkg::ROWS) && (int'(in_col) < gds_pkg::COLS);
  assign stack_full = (cnt_r >= gds_pkg::CNT_W'(gds_pkg::STACK_DEPTH));
  assign nb_inc     = nb_r + gds_pkg::NBR_W'(1);

  always_comb begin
    nbr_row[0] = pr_r + gds_pkg::ROW_W'(1);
    nbr_col[0] = pc_r;
    nbr_ok[0]  = (int'(pr_r) + 1) < gds_pkg::ROWS;
    nbr_row[1] = pr_r - gds_pkg::ROW_W'(1);
    nbr_col[1] = pc_r;
    nbr_ok[1]  = (pr_r != '0);
    nbr_row[2] = pr_r;
    nbr_col[2] = pc_r + gds_pkg::COL_W'(1);
    nbr_ok[2]  = (int'(pc_r) + 1) < gds_pkg::COLS;
    nbr_row[3] = pr_r;
    nbr_col[3] = pc_r - gds_pkg::COL_W'(1);
    nbr_ok[3]  = (pc_r != '0);
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gds_pkg::ST_CLEAR: begin
        if (clr_r == gds_pkg::GRID_AW'(gds_pkg::GRID_DEPTH - 1)) begin
          state_nxt = gds_pkg::ST_IDLE;
        end
      end
      gds_pkg::ST_IDLE: begin
        if (accept && (in_operation == gds_pkg::OP_STEP) && (cnt_r != '0)) begin
          state_nxt = gds_pkg::ST_POP;
        end
      end
      gds_pkg::ST_POP: state_nxt = gds_pkg::ST_CELL;
      gds_pkg::ST_CELL: begin
        if (g_rdata == gds_pkg::CELL_VISITED) begin
          state_nxt = gds_pkg::ST_IDLE;
        end else begin
          state_nxt = gds_pkg::ST_NBR;
        end
      end
      gds_pkg::ST_NBR: begin
        if (nb_r == gds_pkg::NBR_LAST) begin
          state_nxt = gds_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gds_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory controls and result word.
  always_comb begin
    cnt_nxt     = cnt_r;
    clr_nxt     = clr_r;
    pr_nxt      = pr_r;
    pc_nxt      = pc_r;
    nb_nxt      = nb_r;
    ovf_nxt     = ovf_r;
    valid_nxt   = 1'b0;
    changed_nxt = changed_r;
    erow_nxt    = erow_r;
    ecol_nxt    = ecol_r;
    empty_nxt   = empty_r;
    oflag_nxt   = oflag_r;

    g_we    = 1'b0;
    g_waddr = gds_pkg::cell_addr(pr_r, pc_r);
    g_wdata = gds_pkg::CELL_VISITED;
    g_raddr = gds_pkg::cell_addr(pr_r, pc_r);
    s_we    = 1'b0;
    s_waddr = cnt_r[gds_pkg::STACK_AW-1:0];
    s_wdata = {in_row, in_col};
    s_raddr = cnt_r[gds_pkg::STACK_AW-1:0];

    case (state_r)
      gds_pkg::ST_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = clr_r;
        g_wdata = gds_pkg::CELL_OPEN;
        clr_nxt = clr_r + gds_pkg::GRID_AW'(1);
      end

      gds_pkg::ST_IDLE: begin
        if (accept) begin
          changed_nxt = 1'b0;
          erow_nxt    = '0;
          ecol_nxt    = '0;
          oflag_nxt   = 1'b0;
          ovf_nxt     = 1'b0;
          valid_nxt   = 1'b1;
          case (in_operation)
            gds_pkg::OP_WRITE: begin
              if (in_grid) begin
                g_we    = 1'b1;
                g_waddr = gds_pkg::cell_addr(in_row, in_col);
                g_wdata = in_cell_value;
              end
            end
            gds_pkg::OP_SEED: begin
              if (in_grid) begin
                if (stack_full) begin
                  oflag_nxt = 1'b1;
                end else begin
                  s_we    = 1'b1;
                  cnt_nxt = cnt_r + gds_pkg::CNT_W'(1);
                end
              end
            end
            gds_pkg::OP_STEP: begin
              if (cnt_r != '0) begin
                // Pop: the top entry is read while the result waits for the search.
                cnt_nxt   = cnt_r - gds_pkg::CNT_W'(1);
                s_raddr   = cnt_nxt[gds_pkg::STACK_AW-1:0];
                valid_nxt = 1'b0;
              end
            end
            default: begin
            end
          endcase
          empty_nxt = (cnt_nxt == '0);
        end
      end

      gds_pkg::ST_POP: begin
        pr_nxt  = s_rdata[gds_pkg::STK_W-1:gds_pkg::COL_W];
        pc_nxt  = s_rdata[gds_pkg::COL_W-1:0];
        g_raddr = gds_pkg::cell_addr(pr_nxt, pc_nxt);
      end

      gds_pkg::ST_CELL: begin
        erow_nxt = pr_r;
        ecol_nxt = pc_r;
        if (g_rdata == gds_pkg::CELL_VISITED) begin
          changed_nxt = 1'b0;
          empty_nxt   = (cnt_r == '0);
          valid_nxt   = 1'b1;
        end else begin
          changed_nxt = 1'b1;
          // A source cell keeps its state.
          g_we    = (g_rdata != gds_pkg::CELL_SOURCE);
          g_raddr = gds_pkg::cell_addr(nbr_row[0], nbr_col[0]);
          nb_nxt  = '0;
        end
      end

      gds_pkg::ST_NBR: begin
        // The read for this neighbour is out; the next one is issued now.
        s_wdata = {nbr_row[nb_r], nbr_col[nb_r]};
        if (nbr_ok[nb_r] && (g_rdata == gds_pkg::CELL_OPEN)) begin
          if (stack_full) begin
            ovf_nxt = 1'b1;
          end else begin
            s_we    = 1'b1;
            cnt_nxt = cnt_r + gds_pkg::CNT_W'(1);
          end
        end
        g_raddr = gds_pkg::cell_addr(nbr_row[nb_inc], nbr_col[nb_inc]);
        nb_nxt  = nb_inc;
        if (nb_r == gds_pkg::NBR_LAST) begin
          valid_nxt = 1'b1;
          empty_nxt = (cnt_nxt == '0);
          oflag_nxt = ovf_nxt;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gds_pkg::ST_CLEAR;
      cnt_r   <= '0;
      clr_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      clr_r   <= clr_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pr_r      <= pr_nxt;
    pc_r      <= pc_nxt;
    nb_r      <= nb_nxt;
    ovf_r     <= ovf_nxt;
    changed_r <= changed_nxt;
    erow_r    <= erow_nxt;
    ecol_r    <= ecol_nxt;
    empty_r   <= empty_nxt;
    oflag_r   <= oflag_nxt;
  end

  gds_ram #(
    .WIDTH(gds_pkg::CELL_W),
    .DEPTH(gds_pkg::GRID_DEPTH)
  ) u_grid_ram (
    .clk  (clk),
    .we   (g_we),
    .waddr(g_waddr),
    .wdata(g_wdata),
    .raddr(g_raddr),
    .rdata(g_rdata)
  );

  gds_ram #(
    .WIDTH(gds_pkg::STK_W),
    .DEPTH(gds_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (s_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .raddr(s_raddr),
    .rdata(s_rdata)
  );

  assign busy             = (state_r != gds_pkg::ST_IDLE);
  assign out_valid        = valid_r;
  assign out_changed      = changed_r;
  assign out_expanded_row = erow_r;
  assign out_expanded_col = ecol_r;
  assign out_stack_empty  = empty_r;
  assign out_overflow     = oflag_r;

  // Any command other than a search step always answers in the following cycle.
  a_short_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_operation != gds_pkg::OP_STEP) |=> out_valid)
    else $error("short command gave no result word");

  // A result word only appears once the sequencer is free again.
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word while busy");

  // The pop takes exactly one entry off the stack.
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gds_pkg::ST_POP |-> $past(cnt_r) == cnt_r + gds_pkg::CNT_W'(1))
    else $error("stack count wrong after pop");

  // No result word during the clearing pass.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gds_pkg::ST_CLEAR |-> !out_valid)
    else $error("result word during grid clear");

  // The stack count never passes the stack depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cnt_r) <= gds_pkg::CNT_W'(gds_pkg::STACK_DEPTH)
      |-> cnt_r <= gds_pkg::CNT_W'(gds_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

endmodule

// ===== rtl/gds_ram.sv =====
module gds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== tb/tb_grid_dfs_single_step.sv =====
`default_nettype none

module tb_grid_dfs_single_step;
  timeunit 1ns;
  timeprecision 1ps;

  // The one operation code that the block leaves undefined. A word carrying it
  // must change nothing and only report whether the stack is empty.
  localparam logic [1:0] OP_NONE = 2'd3;

  // Random words outside the directed opening and the stack fill at the end.
  localparam int RANDOM_WORDS = 1400;
  // Only the first few mismatches are printed in full.
  localparam int SHOWN_MISMATCHES = 10;
  // A quiet tail at the end, ample for any stray result word to show itself.
  localparam int TAIL_CYCLES = 20;
  // A bound in ns. The slowest correct run is roughly 5.6k words, each with
  // its search work and any idle gap after it, behind the clearing pass after
  // reset, so this is several times over.
  localparam int TIMEOUT_NS = 5_000_000;

  // The cell at the centre of the stack fill. It is popped when the stack is
  // exactly full, so only its first neighbour fits back on.
  localparam int HUB_ROW = 16;
  localparam int HUB_COL = 16;

  // Neighbour offsets in the order down, up, right, left.
  localparam int NBR_DROW [gds_pkg::NBR_N] = '{1, -1, 0, 0};
  localparam int NBR_DCOL [gds_pkg::NBR_N] = '{0, 0, 1, -1};

  typedef struct {
    logic [1:0]                 op;
    logic [gds_pkg::ROW_W-1:0]  row;
    logic [gds_pkg::COL_W-1:0]  col;
    logic [gds_pkg::CELL_W-1:0] val;
    bit                         may_idle;  // the sender may leave a gap after this word
    bit                         hold;      // present only once every result has come
  } grid_cmd_t;

  typedef struct {
    logic                      changed;
    logic [gds_pkg::ROW_W-1:0] row;
    logic [gds_pkg::COL_W-1:0] col;
    logic                      empty;
    logic                      ovf;
  } search_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Every input is given a known value from time zero.
  logic                       start = 1'b0;
  logic [1:0]                 in_operation = gds_pkg::OP_WRITE;
  logic [gds_pkg::ROW_W-1:0]  in_row = '0;
  logic [gds_pkg::COL_W-1:0]  in_col = '0;
  logic [gds_pkg::CELL_W-1:0] in_cell_value = gds_pkg::CELL_OPEN;

  logic                      busy;
  logic                      out_valid;
  logic                      out_changed;
  logic [gds_pkg::ROW_W-1:0] out_expanded_row;
  logic [gds_pkg::COL_W-1:0] out_expanded_col;
  logic                      out_stack_empty;
  logic                      out_overflow;

  grid_dfs_single_step dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_cell_value    (in_cell_value),
    .out_valid        (out_valid),
    .out_changed      (out_changed),
    .out_expanded_row (out_expanded_row),
    .out_expanded_col (out_expanded_col),
    .out_stack_empty  (out_stack_empty),
    .out_overflow     (out_overflow)
  );

  always #5 clk = ~clk;

  // Our own copy of the grid and of the search stack. The stack holds
  // {row, col}; its top is the back of the queue.
  logic [gds_pkg::CELL_W-1:0] shadow_grid [gds_pkg::GRID_DEPTH] =
    '{default: gds_pkg::CELL_OPEN};
  logic [gds_pkg::STK_W-1:0]  shadow_stack [$];

  grid_cmd_t    queued_cmds [$];     // words still to be offered to the block
  search_word_t predicted_words [$]; // results owed by the block, oldest first

  grid_cmd_t    drive_cmd;
  search_word_t want;
  bit           word_taken;
  bit           gen_idles;
  int           idle_left;

  int stim_words;
  int words_sent;
  int results_checked;
  int mismatches;
  int expansions;
  int visited_pops;
  int empty_steps;
  int dropped_pushes;

  function automatic int grid_index(input int r, input int c);
    return r * gds_pkg::COLS + c;
  endfunction

  // Applies one accepted word to the shadow grid and stack and returns the
  // result word that the block owes for it.
  function automatic search_word_t predict_search_word(input grid_cmd_t c);
    search_word_t              w;
    logic [gds_pkg::STK_W-1:0] top;
    int                        pr, pc, nr, nc;
    bit                        on_grid;
    w = '{changed: 1'b0, row: '0, col: '0, empty: 1'b0, ovf: 1'b0};
    on_grid = (int'(c.row) < gds_pkg::ROWS) && (int'(c.col) < gds_pkg::COLS);
    case (c.op)
      gds_pkg::OP_WRITE: begin
        if (on_grid) shadow_grid[grid_index(c.row, c.col)] = c.val;
      end
      gds_pkg::OP_SEED: begin
        if (on_grid) begin
          if (shadow_stack.size() < gds_pkg::STACK_DEPTH) begin
            shadow_stack.push_back({c.row, c.col});
          end else begin
            w.ovf = 1'b1;
            dropped_pushes++;
          end
        end
      end
      gds_pkg::OP_STEP: begin
        if (shadow_stack.size() == 0) begin
          empty_steps++;
        end else begin
          top = shadow_stack.pop_back();
          w.row = top[gds_pkg::STK_W-1:gds_pkg::COL_W];
          w.col = top[gds_pkg::COL_W-1:0];
          pr = int'(w.row);
          pc = int'(w.col);
          // A popped cell that is already visited is reported but not expanded.
          if (shadow_grid[grid_index(pr, pc)] == gds_pkg::CELL_VISITED) begin
            visited_pops++;
          end else begin
            w.changed = 1'b1;
            expansions++;
            // The source keeps its state so that it is never mistaken for
            // an ordinary visited cell.
            if (shadow_grid[grid_index(pr, pc)] != gds_pkg::CELL_SOURCE)
              shadow_grid[grid_index(pr, pc)] = gds_pkg::CELL_VISITED;
            for (int i = 0; i < gds_pkg::NBR_N; i++) begin
              nr = pr + NBR_DROW[i];
              nc = pc + NBR_DCOL[i];
              // Walls, visited cells and the source are all passed over, which
              // leaves only open cells to be pushed.
              if (nr >= 0 && nr < gds_pkg::ROWS && nc >= 0 && nc < gds_pkg::COLS &&
                  shadow_grid[grid_index(nr, nc)] == gds_pkg::CELL_OPEN) begin
                if (shadow_stack.size() < gds_pkg::STACK_DEPTH) begin
                  shadow_stack.push_back({nr[gds_pkg::ROW_W-1:0], nc[gds_pkg::COL_W-1:0]});
                end else begin
                  // A dropped push does not stop the later neighbours.
                  w.ovf = 1'b1;
                  dropped_pushes++;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
    w.empty = (shadow_stack.size() == 0);
    return w;
  endfunction

  task automatic add_cmd(input logic [1:0] op, input int r, input int c, input int v,
                         input bit hold);
    grid_cmd_t g;
    g.op = op;
    g.row = r[gds_pkg::ROW_W-1:0];
    g.col = c[gds_pkg::COL_W-1:0];
    g.val = v[gds_pkg::CELL_W-1:0];
    g.may_idle = gen_idles;
    g.hold = hold;
    queued_cmds.push_back(g);
    if (op != OP_NONE) stim_words++;
  endtask

  // Returns once nothing is queued, nothing is being offered and every result
  // owed has come back.
  task automatic wait_quiet();
    while (!(queued_cmds.size() == 0 && !start && predicted_words.size() == 0))
      @(posedge clk);
  endtask

  // Sender. A word is taken at an edge where start is high and busy is low.
  // Its result is predicted at that same edge, so predictions follow the order
  // in which the block sees the words. After a taken word the sender may leave
  // a short gap; otherwise it offers the next word straight away, which keeps
  // start high across back-to-back words with a single assignment per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      word_taken = start && !busy;
      if (word_taken) begin
        predicted_words.push_back(predict_search_word(drive_cmd));
        words_sent++;
        if (drive_cmd.may_idle && $urandom_range(0, 3) == 0)
          idle_left = $urandom_range(1, 7);
      end
      if (word_taken || !start) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (queued_cmds.size() != 0 &&
                     !(queued_cmds[0].hold && predicted_words.size() != 0)) begin
          drive_cmd = queued_cmds.pop_front();
          in_operation <= drive_cmd.op;
          in_row <= drive_cmd.row;
          in_col <= drive_cmd.col;
          in_cell_value <= drive_cmd.val;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Receiver. A result word stands for one cycle only, so it is sampled at the
  // edge that ends that cycle and matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (predicted_words.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display({"%0t ns: result word with none expected: ",
                    "changed=%0b row=%0d col=%0d empty=%0b ovf=%0b"},
                   $time, out_changed, out_expanded_row, out_expanded_col,
                   out_stack_empty, out_overflow);
      end else begin
        want = predicted_words.pop_front();
        results_checked++;
        if (out_changed !== want.changed || out_expanded_row !== want.row ||
            out_expanded_col !== want.col || out_stack_empty !== want.empty ||
            out_overflow !== want.ovf) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display({"%0t ns: mismatch, expected changed=%0b row=%0d col=%0d ",
                      "empty=%0b ovf=%0b, got changed=%0b row=%0d col=%0d ",
                      "empty=%0b ovf=%0b"},
                     $time, want.changed, want.row, want.col, want.empty, want.ovf,
                     out_changed, out_expanded_row, out_expanded_col,
                     out_stack_empty, out_overflow);
        end
      end
    end
  end

  initial begin
    int random_target, episodes, pick, h, w, r0, c0, sr, sc, x, fill;
    bit hold_next;
    episodes = 0;
    gen_idles = 1'b1;

    // Directed opening. The stack starts empty and the grid all open.
    add_cmd(gds_pkg::OP_STEP, 0, 0, 0, 1'b0);          // step on an empty stack
    add_cmd(OP_NONE, 31, 31, 3, 1'b0);                 // undefined code, all ones
    add_cmd(gds_pkg::OP_WRITE, 0, 1, gds_pkg::CELL_WALL, 1'b0);
    add_cmd(gds_pkg::OP_WRITE, 0, 0, gds_pkg::CELL_SOURCE, 1'b0);
    add_cmd(gds_pkg::OP_SEED, 0, 0, 0, 1'b0);
    add_cmd(gds_pkg::OP_STEP, 0, 0, 0, 1'b0);          // source popped: stays source
    add_cmd(gds_pkg::OP_STEP, 31, 31, 3, 1'b0);        // pops (1,0), skips the source
    add_cmd(gds_pkg::OP_WRITE, 1, 1, gds_pkg::CELL_VISITED, 1'b0);
    add_cmd(gds_pkg::OP_STEP, 0, 0, 0, 1'b0);          // pops a visited cell
    add_cmd(gds_pkg::OP_STEP, 0, 0, 0, 1'b0);
    add_cmd(gds_pkg::OP_WRITE, 31, 31, gds_pkg::CELL_OPEN, 1'b0);
    add_cmd(gds_pkg::OP_SEED, 31, 31, 3, 1'b0);
    add_cmd(gds_pkg::OP_STEP, 0, 0, 0, 1'b0);          // far corner: only up and left
    add_cmd(gds_pkg::OP_SEED, 31, 31, 0, 1'b0);
    add_cmd(gds_pkg::OP_STEP, 0, 0, 0, 1'b0);          // same corner again, now visited
    add_cmd(gds_pkg::OP_SEED, 0, 31, 2, 1'b0);
    add_cmd(gds_pkg::OP_STEP, 0, 0, 0, 1'b0);
    add_cmd(gds_pkg::OP_SEED, 31, 0, 1, 1'b0);
    add_cmd(gds_pkg::OP_STEP, 0, 0, 0, 1'b0);
    add_cmd(gds_pkg::OP_SEED, 15, 16, 0, 1'b0);
    add_cmd(gds_pkg::OP_STEP, 0, 0, 0, 1'b0);          // interior cell, four neighbours
    add_cmd(gds_pkg::OP_STEP, 0, 0, 0, 1'b0);

    // Random part. Most of it is small searches: a window of the grid is
    // painted, a cell in it is seeded and a run of steps walks the search.
    // The rest is loose noise, bare steps and bare seeds.
    random_target = stim_words + RANDOM_WORDS;
    while (stim_words < random_target) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        episodes++;
        // Now and then the sender waits for every result before a search.
        hold_next = (episodes % 12 == 0);
        h = $urandom_range(2, 4);
        w = $urandom_range(2, 4);
        r0 = $urandom_range(0, gds_pkg::ROWS - h);
        c0 = $urandom_range(0, gds_pkg::COLS - w);
        for (int r = r0; r < r0 + h; r++) begin
          for (int c = c0; c < c0 + w; c++) begin
            x = $urandom_range(0, 19);
            add_cmd(gds_pkg::OP_WRITE, r, c,
                    x < 12 ? gds_pkg::CELL_OPEN : x < 17 ? gds_pkg::CELL_WALL :
                    x < 19 ? gds_pkg::CELL_VISITED : gds_pkg::CELL_SOURCE, hold_next);
            hold_next = 1'b0;
          end
        end
        sr = $urandom_range(r0, r0 + h - 1);
        sc = $urandom_range(c0, c0 + w - 1);
        add_cmd(gds_pkg::OP_WRITE, sr, sc,
                $urandom_range(0, 1) ? gds_pkg::CELL_SOURCE : gds_pkg::CELL_OPEN, 1'b0);
        add_cmd(gds_pkg::OP_SEED, sr, sc, $urandom_range(0, 3), 1'b0);
        repeat ($urandom_range(2, 14))
          add_cmd(gds_pkg::OP_STEP, $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 3), 1'b0);
      end else if (pick == 7) begin
        repeat ($urandom_range(1, 4))
          add_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 3), 1'b0);
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 6))
          add_cmd(gds_pkg::OP_STEP, $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 3), 1'b0);
      end else begin
        repeat ($urandom_range(1, 3))
          add_cmd(gds_pkg::OP_SEED, $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 3), 1'b0);
        repeat ($urandom_range(1, 3))
          add_cmd(gds_pkg::OP_STEP, $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 3), 1'b0);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Once the random part has fully drained, the shadow stack depth is exact,
    // so the stack can be filled to one short of full with seeds and topped up
    // with the hub cell. The fill runs without gaps.
    wait_quiet();
    gen_idles = 1'b0;
    add_cmd(gds_pkg::OP_WRITE, HUB_ROW, HUB_COL, gds_pkg::CELL_OPEN, 1'b0);
    for (int i = 0; i < gds_pkg::NBR_N; i++)
      add_cmd(gds_pkg::OP_WRITE, HUB_ROW + NBR_DROW[i], HUB_COL + NBR_DCOL[i],
              gds_pkg::CELL_OPEN, 1'b0);
    fill = gds_pkg::STACK_DEPTH - shadow_stack.size() - 1;
    for (int i = 0; i < fill; i++)
      add_cmd(gds_pkg::OP_SEED, $urandom_range(0, 31), $urandom_range(0, 31),
              $urandom_range(0, 3), 1'b0);
    add_cmd(gds_pkg::OP_SEED, HUB_ROW, HUB_COL, 0, 1'b0);
    // The stack is now full, so these seeds are dropped.
    repeat (3)
      add_cmd(gds_pkg::OP_SEED, $urandom_range(0, 31), $urandom_range(0, 31),
              $urandom_range(0, 3), 1'b0);
    // The hub pops with four open neighbours: the first fills the freed slot
    // and the other three are dropped.
    repeat (8)
      add_cmd(gds_pkg::OP_STEP, $urandom_range(0, 31), $urandom_range(0, 31),
              $urandom_range(0, 3), 1'b0);

    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d command words and checked %0d result words (%0d search windows).",
             words_sent, results_checked, episodes);
    $display("Cells expanded %0d, visited pops %0d, empty-stack steps %0d, pushes dropped %0d.",
             expansions, visited_pops, empty_steps, dropped_pushes);
    if (mismatches == 0) begin
      $display("grid_dfs_single_step test passed");
    end else begin
      $display("grid_dfs_single_step test failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d words queued and %0d results outstanding.",
             queued_cmds.size(), predicted_words.size());
    $display("grid_dfs_single_step test failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/gds_pkg.sv
rtl/gds_ram.sv
rtl/grid_dfs_single_step.sv
tb/tb_grid_dfs_single_step.sv
